FILE: rtl/core/ffba_pkg.sv
// shared types and constants for the first-fit block allocator
package ffba_pkg;

  localparam int RECORDS_DEF   = 64;
  localparam int ADDR_BITS_DEF = 16;

  localparam int FIELD_W  = 16;
  localparam int NEED_W   = FIELD_W + 1;
  localparam int STATUS_W = 2;
  localparam int GRANULE  = 8;
  localparam int IN_W     = 2 * FIELD_W;
  localparam int OUT_W    = ((STATUS_W + FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD  = OUT_W - STATUS_W - FIELD_W;

  localparam logic [FIELD_W-1:0] REGION_RESET = 16'hFFFF;

  typedef enum logic [0:0] {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_NO_SPARE  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_WALK,
    S_FIX,
    S_DONE
  } state_t;

  typedef struct packed {
    logic fit;
    logic exact;
    logic match;
  } flags_t;

endpackage

FILE: rtl/core/first_fit_block_allocator_core.sv
// top level of the first-fit block allocator
//
// first-fit allocator over a region of region_size bytes. block records
// (offset, length, link) live in one record memory of RECORDS entries and
// form a free list and an allocated list; unused records are handed out in
// index order by a counter and never come back. an allocate item rounds the
// request up to a multiple of 8 bytes and walks the free list from its head,
// one record per cycle through the memory's registered read port, until a
// block fits; an exact fit moves the record to the allocated list, a larger
// block is split with a fresh record taking the low part. a free item walks
// the allocated list newest first for a matching offset and moves it to the
// free list. each item gives one result item (status, granted_address). the
// walk visits at most RECORDS records, none when the walked list is empty; a
// hit that needs the write-back passes through S_FIX before S_DONE, while a
// miss, a split with no spare record or an empty list goes straight to S_DONE.
// s_tready is low for the whole item. after reset and after every region_size
// write the block writes record 0 in S_INIT before it takes an item; there is
// no clearing pass.
module first_fit_block_allocator_core #(
  parameter int RECORDS   = ffba_pkg::RECORDS_DEF,
  parameter int ADDR_BITS = ffba_pkg::ADDR_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // region_size write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ffba_pkg::FIELD_W-1:0] cfg_data,
  // request items
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [ffba_pkg::IN_W-1:0]    s_tdata,  // request_bytes, block_address
  input  logic                         s_tuser,  // action
  // result items
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [ffba_pkg::OUT_W-1:0]   m_tdata   // status, granted_address, zero pad
);
  import ffba_pkg::*;

  localparam int IDX_W  = $clog2(RECORDS);
  localparam int LINK_W = $clog2(RECORDS + 1);
  localparam int LEN_W  = ADDR_BITS + 1;
  localparam int WORD_W = LINK_W + LEN_W + ADDR_BITS;
  localparam logic [LINK_W-1:0] NIL = LINK_W'(RECORDS);

  // sequencer state
  state_t state;
  state_t state_next;

  // lists and region
  logic [FIELD_W-1:0] region_size;
  logic [LINK_W-1:0]  free_head;
  logic [LINK_W-1:0]  alloc_head;
  logic [LINK_W-1:0]  spare_head;

  // current item
  action_t             act;
  logic [NEED_W-1:0]   need;
  logic [ADDR_BITS-1:0] key;
  logic                split;
  status_t             res_status;
  logic [FIELD_W-1:0]  res_granted;

  // walk position
  logic [IDX_W-1:0]     cur;
  logic [IDX_W-1:0]     prev;
  logic                 prev_valid;
  logic [ADDR_BITS-1:0] prev_offset;
  logic [LEN_W-1:0]     prev_length;
  logic [ADDR_BITS-1:0] cur_offset;
  logic [LEN_W-1:0]     cur_length;
  logic [LINK_W-1:0]    cur_link;

  // memory ports
  logic                 mem_wr_en;
  logic [IDX_W-1:0]     mem_wr_addr;
  logic [WORD_W-1:0]    mem_wr_data;
  logic                 mem_rd_en;
  logic [IDX_W-1:0]     mem_rd_addr;
  logic [WORD_W-1:0]    mem_rd_data;

  logic [ADDR_BITS-1:0] rd_off;
  logic [LEN_W-1:0]     rd_len;
  logic [LINK_W-1:0]    rd_link;

  // shared unit
  logic [ADDR_BITS-1:0] alu_offset;
  logic [LEN_W-1:0]     alu_length;
  flags_t               flags;
  logic [ADDR_BITS-1:0] rest_offset;
  logic [LEN_W-1:0]     rest_length;

  logic                 in_acc;
  logic                 cfg_acc;
  logic                 out_free;
  logic                 hit;
  logic                 need_spare;
  logic [LINK_W-1:0]    head_sel;
  logic [NEED_W-1:0]    need_in;

  ffba_rec_mem #(
    .DEPTH (RECORDS),
    .WIDTH (WORD_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // compare during the walk, add/subtract on the split write-back
  ffba_alu #(
    .ADDR_BITS (ADDR_BITS)
  ) u_alu (
    .rec_offset  (alu_offset),
    .rec_length  (alu_length),
    .need        (need),
    .key         (key),
    .flags       (flags),
    .rest_offset (rest_offset),
    .rest_length (rest_length)
  );

  always_comb begin
    rd_off  = mem_rd_data[ADDR_BITS-1:0];
    rd_len  = mem_rd_data[ADDR_BITS +: LEN_W];
    rd_link = mem_rd_data[ADDR_BITS+LEN_W +: LINK_W];

    alu_offset = (state == S_FIX) ? cur_offset : rd_off;
    alu_length = (state == S_FIX) ? cur_length : rd_len;

    hit        = (act == ACT_FREE) ? flags.match : flags.fit;
    need_spare = (act == ACT_ALLOC) && !flags.exact;

    // free walks the allocated list, allocate walks the free list
    head_sel = (action_t'(s_tuser) == ACT_FREE) ? alloc_head : free_head;

    // round up to the granule
    need_in = ({1'b0, s_tdata[FIELD_W-1:0]} + NEED_W'(GRANULE - 1))
              & ~NEED_W'(GRANULE - 1);

    in_acc   = s_tvalid && s_tready;
    cfg_acc  = cfg_valid && cfg_ready;
    out_free = !m_tvalid || m_tready;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_acc) begin
          state_next = S_INIT;
        end else if (in_acc) begin
          state_next = (head_sel == NIL) ? S_DONE : S_WALK;
        end
      end
      S_WALK: begin
        if (hit) begin
          state_next = (need_spare && spare_head == NIL) ? S_DONE : S_FIX;
        end else if (rd_link == NIL) begin
          state_next = S_DONE;
        end
      end
      S_FIX: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  // handshakes and memory control
  always_comb begin
    s_tready    = 1'b0;
    cfg_ready   = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = '0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    case (state)
      S_INIT: begin
        // record 0 holds the whole region
        mem_wr_en   = 1'b1;
        mem_wr_data = {NIL, LEN_W'(region_size), ADDR_BITS'(0)};
      end
      S_IDLE: begin
        cfg_ready   = 1'b1;
        s_tready    = !cfg_valid;
        mem_rd_en   = in_acc && (head_sel != NIL);
        mem_rd_addr = head_sel[IDX_W-1:0];
      end
      S_WALK: begin
        if (hit) begin
          if (need_spare) begin
            // fresh record takes the low part onto the allocated list
            mem_wr_en   = spare_head != NIL;
            mem_wr_addr = spare_head[IDX_W-1:0];
            mem_wr_data = {alloc_head, LEN_W'(need), rd_off};
          end else begin
            // unlink from the predecessor
            mem_wr_en   = prev_valid;
            mem_wr_addr = prev;
            mem_wr_data = {rd_link, prev_length, prev_offset};
          end
        end else begin
          mem_rd_en   = rd_link != NIL;
          mem_rd_addr = rd_link[IDX_W-1:0];
        end
      end
      S_FIX: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = cur;
        if (split) begin
          mem_wr_data = {cur_link, rest_length, rest_offset};
        end else if (act == ACT_FREE) begin
          mem_wr_data = {free_head, cur_length, cur_offset};
        end else begin
          mem_wr_data = {alloc_head, cur_length, cur_offset};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_size <= REGION_RESET;
      free_head   <= '0;
      alloc_head  <= NIL;
      spare_head  <= LINK_W'(1);
      m_tvalid    <= 1'b0;
    end else begin
      // result goes out once the previous one has left
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          free_head  <= '0;
          alloc_head <= NIL;
          spare_head <= LINK_W'(1);
        end
        S_IDLE: begin
          if (cfg_acc) begin
            region_size <= cfg_data;
          end
        end
        S_WALK: begin
          if (hit && need_spare && spare_head != NIL) begin
            alloc_head <= spare_head;
            spare_head <= spare_head + LINK_W'(1);
          end else if (hit && !need_spare && !prev_valid) begin
            // match was the list head
            if (act == ACT_FREE) begin
              alloc_head <= rd_link;
            end else begin
              free_head <= rd_link;
            end
          end
        end
        S_FIX: begin
          if (!split) begin
            if (act == ACT_FREE) begin
              free_head <= LINK_W'(cur);
            end else begin
              alloc_head <= LINK_W'(cur);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // item payload and walk registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          act         <= action_t'(s_tuser);
          need        <= need_in;
          key         <= ADDR_BITS'(s_tdata[IN_W-1:FIELD_W]);
          cur         <= head_sel[IDX_W-1:0];
          prev_valid  <= 1'b0;
          split       <= 1'b0;
          res_granted <= '0;
          // failure unless the walk finds a block
          res_status  <= (action_t'(s_tuser) == ACT_FREE) ? ST_NOT_FOUND : ST_NO_FIT;
        end
      end
      S_WALK: begin
        if (hit) begin
          cur_offset <= rd_off;
          cur_length <= rd_len;
          cur_link   <= rd_link;
          if (need_spare) begin
            if (spare_head == NIL) begin
              res_status <= ST_NO_SPARE;
            end else begin
              split       <= 1'b1;
              res_granted <= FIELD_W'(rd_off);
            end
          end else if (act == ACT_ALLOC) begin
            res_granted <= FIELD_W'(rd_off);
          end
        end else begin
          prev        <= cur;
          prev_valid  <= 1'b1;
          prev_offset <= rd_off;
          prev_length <= rd_len;
          cur         <= rd_link[IDX_W-1:0];
        end
      end
      S_FIX: begin
        res_status <= ST_OK;
      end
      S_DONE: begin
        if (out_free) begin
          m_tdata <= {{OUT_PAD{1'b0}}, res_granted, res_status};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/ffba_rec_mem.sv
// record memory: one write port, one registered read port
module ffba_rec_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 40
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/ffba_alu.sv
// shared compare and add/subtract unit for walking and splitting records
module ffba_alu #(
  parameter int ADDR_BITS = 16
) (
  input  logic [ADDR_BITS-1:0]      rec_offset,
  input  logic [ADDR_BITS:0]        rec_length,
  input  logic [ffba_pkg::NEED_W-1:0] need,
  input  logic [ADDR_BITS-1:0]      key,
  output ffba_pkg::flags_t          flags,
  output logic [ADDR_BITS-1:0]      rest_offset,
  output logic [ADDR_BITS:0]        rest_length
);
  import ffba_pkg::*;

  localparam int LEN_W = ADDR_BITS + 1;
  localparam int CW    = (LEN_W > NEED_W) ? LEN_W : NEED_W;

  logic [CW-1:0] len_x;
  logic [CW-1:0] need_x;
  logic [CW-1:0] sum;
  logic [CW-1:0] diff;

  always_comb begin
    len_x       = CW'(rec_length);
    need_x      = CW'(need);
    flags.fit   = len_x >= need_x;
    flags.exact = len_x == need_x;
    flags.match = rec_offset == key;
    sum         = CW'(rec_offset) + need_x;
    diff        = len_x - need_x;
    rest_offset = sum[ADDR_BITS-1:0];
    rest_length = diff[LEN_W-1:0];
  end

endmodule

FILE: rtl/core/ffba_checker.sv
// port-level checks for the first-fit block allocator, bound to the top level
module ffba_assertions (
  input logic                       clk,
  input logic                       rst,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [ffba_pkg::OUT_W-1:0] m_tdata
);
  import ffba_pkg::*;

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // a failed request never grants an address
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[STATUS_W-1:0] != ST_OK)
      |-> m_tdata[STATUS_W+FIELD_W-1:STATUS_W] == '0)
    else $error("granted address on failure");

  // one item at a time
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready && !cfg_ready)
    else $error("ready while an item is in work");

  // region write rebuilds the lists before the next item
  a_init_after_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !s_tready)
    else $error("item taken during list rebuild");

endmodule

bind first_fit_block_allocator_core ffba_assertions u_ffba_assertions (.*);

FILE: verif/ffba_checker.sv
// result checker for the first-fit block allocator: predicts every result item and compares
module ffba_checker #(
  parameter int RECORDS = ffba_pkg::RECORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [ffba_pkg::FIELD_W-1:0] cfg_data,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [ffba_pkg::IN_W-1:0]    s_tdata,   // request_bytes, block_address
  input  logic                         s_tuser,   // action
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [ffba_pkg::OUT_W-1:0]   m_tdata,   // status, granted_address, zero pad
  output int                           pending,
  output int                           errors
);
  import ffba_pkg::*;

  localparam int LINK_W = $clog2(RECORDS + 1);
  typedef logic [LINK_W-1:0] rec_idx_t;
  localparam rec_idx_t NO_REC = rec_idx_t'(RECORDS);

  typedef struct {
    status_t            st;
    logic [FIELD_W-1:0] addr;
  } grant_t;

  // shadow record memory and list heads
  logic [FIELD_W-1:0] blk_off  [RECORDS];
  logic [NEED_W-1:0]  blk_len  [RECORDS];
  rec_idx_t           blk_next [RECORDS];
  rec_idx_t           free_head, used_head, spare_head;

  grant_t expected_grants[$];

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t ffba_checker: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic void reload_region(input logic [FIELD_W-1:0] size);
    for (int i = 0; i < RECORDS; i++) begin
      blk_off[i]  = '0;
      blk_len[i]  = '0;
      blk_next[i] = (i + 1 < RECORDS) ? rec_idx_t'(i + 1) : NO_REC;
    end
    blk_next[0] = NO_REC;
    blk_len[0]  = {1'b0, size};
    free_head   = '0;
    used_head   = NO_REC;
    spare_head  = rec_idx_t'(1);
  endfunction

  // first fit over the free list, exact fit moves the record, else split
  function automatic void grant_block(input logic [FIELD_W-1:0] req, output status_t st,
                                      output logic [FIELD_W-1:0] addr);
    logic [NEED_W-1:0] need;
    rec_idx_t prev, cur, nr;
    int steps;
    need  = ({1'b0, req} + NEED_W'(GRANULE - 1)) & ~NEED_W'(GRANULE - 1);
    st    = ST_OK;
    addr  = '0;
    prev  = NO_REC;
    cur   = free_head;
    steps = 0;
    while (cur < RECORDS && steps < RECORDS && blk_len[cur] < need) begin
      prev = cur;
      cur  = blk_next[cur];
      steps++;
    end
    if (cur >= RECORDS || blk_len[cur] < need) begin
      st = ST_NO_FIT;
    end else if (blk_len[cur] == need) begin
      if (prev < RECORDS) blk_next[prev] = blk_next[cur];
      else free_head = blk_next[cur];
      blk_next[cur] = used_head;
      used_head     = cur;
      addr          = blk_off[cur];
    end else if (spare_head >= RECORDS) begin
      st = ST_NO_SPARE;
    end else begin
      nr            = spare_head;
      spare_head    = blk_next[nr];
      blk_off[nr]   = blk_off[cur];
      blk_len[nr]   = need;
      blk_next[nr]  = used_head;
      used_head     = nr;
      blk_off[cur]  = blk_off[cur] + need[FIELD_W-1:0];
      blk_len[cur]  = blk_len[cur] - need;
      addr          = blk_off[nr];
    end
  endfunction

  // newest-first search of the allocated list, match goes to the free head
  function automatic status_t release_block(input logic [FIELD_W-1:0] addr);
    rec_idx_t prev, cur;
    int steps;
    prev  = NO_REC;
    cur   = used_head;
    steps = 0;
    while (cur < RECORDS && steps < RECORDS && blk_off[cur] != addr) begin
      prev = cur;
      cur  = blk_next[cur];
      steps++;
    end
    if (cur >= RECORDS || blk_off[cur] != addr) return ST_NOT_FOUND;
    if (prev < RECORDS) blk_next[prev] = blk_next[cur];
    else used_head = blk_next[cur];
    blk_next[cur] = free_head;
    free_head     = cur;
    return ST_OK;
  endfunction

  always @(posedge clk) begin
    grant_t g, want;
    if (rst) begin
      reload_region(REGION_RESET);
      expected_grants.delete();
      errors = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_grants.size() == 0) begin
          flag_mismatch("result item with nothing expected", 32'(m_tdata), 0);
        end else begin
          want = expected_grants.pop_front();
          if (m_tdata[STATUS_W-1:0] != want.st)
            flag_mismatch("status", 32'(m_tdata[STATUS_W-1:0]), 32'(want.st));
          if (m_tdata[STATUS_W +: FIELD_W] != want.addr)
            flag_mismatch("granted_address", 32'(m_tdata[STATUS_W +: FIELD_W]),
                          32'(want.addr));
          if (m_tdata[OUT_W-1:STATUS_W+FIELD_W] != '0)
            flag_mismatch("pad bits", 32'(m_tdata[OUT_W-1:STATUS_W+FIELD_W]), 0);
        end
      end
      if (cfg_valid && cfg_ready) reload_region(cfg_data);
      if (s_tvalid && s_tready) begin
        if (action_t'(s_tuser) == ACT_ALLOC) begin
          grant_block(s_tdata[FIELD_W-1:0], g.st, g.addr);
        end else begin
          g.st   = release_block(s_tdata[FIELD_W +: FIELD_W]);
          g.addr = '0;
        end
        expected_grants.push_back(g);
      end
    end
    pending = expected_grants.size();
  end

endmodule

FILE: verif/tb_top.sv
// testbench top for the first-fit block allocator: stimulus, stalls, watchdog and verdict
module tb_top;
  import ffba_pkg::*;

  localparam int RECORDS     = RECORDS_DEF;
  // worst quiet stretch is a long sender gap, then a full walk, then a long
  // receiver stall; the limit leaves a wide margin
  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASES      = 13;
  localparam int PHASE_ITEMS = 125;

  typedef struct {
    action_t           act;
    logic [NEED_W-1:0] size;
  } sent_t;

  typedef struct {
    logic [FIELD_W-1:0] addr;
    logic [NEED_W-1:0]  size;
  } held_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [FIELD_W-1:0] cfg_data = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [IN_W-1:0]    s_tdata = '0;   // request_bytes, block_address
  logic               s_tuser = 1'b0; // action
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;        // status, granted_address, zero pad

  int chk_pending, chk_errors;

  // stimulus bookkeeping: items in flight, blocks believed held, sizes freed
  sent_t             sent_q[$];
  held_t             held_q[$];
  logic [NEED_W-1:0] freed_sizes[$];

  bit no_idle = 1'b0;     // set for whole phases to run back to back
  int cur_region = 65535;
  int quiet_cycles = 0;
  int n_alloc = 0, n_free = 0, n_regions = 0;
  int status_seen[4] = '{0, 0, 0, 0};

  first_fit_block_allocator_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  ffba_checker #(.RECORDS(RECORDS)) chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .pending   (chk_pending),
    .errors    (chk_errors)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // random filler for a field the item does not use
  function automatic logic [FIELD_W-1:0] rand_field();
    return FIELD_W'($urandom);
  endfunction

  // result side back-pressure, free running so stalls land on any cycle
  initial begin
    int gap;
    forever begin
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  // watch results only to steer later frees and to tally the statuses seen
  always @(posedge clk) begin
    sent_t s;
    if (!rst && m_tvalid && m_tready && sent_q.size() > 0) begin
      s = sent_q.pop_front();
      status_seen[m_tdata[STATUS_W-1:0]]++;
      if (s.act == ACT_ALLOC && status_t'(m_tdata[STATUS_W-1:0]) == ST_OK)
        held_q.push_back('{m_tdata[STATUS_W +: FIELD_W], s.size});
    end
  end

  // watchdog: any handshake restarts the count of quiet cycles
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called and returns at a falling edge; valid stays high across
  // back-to-back items and only drops when a gap is taken
  task automatic push_request(input action_t act, input logic [FIELD_W-1:0] req,
                              input logic [FIELD_W-1:0] addr);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {addr, req};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_q.push_back('{act, ({1'b0, req} + NEED_W'(GRANULE - 1)) & ~NEED_W'(GRANULE - 1)});
    if (act == ACT_ALLOC) n_alloc++;
    else n_free++;
    @(negedge clk);
  endtask

  // region writes only once every result is back, so the block is idle
  task automatic write_region(input logic [FIELD_W-1:0] size);
    s_tvalid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    held_q.delete();
    freed_sizes.delete();
    cur_region = int'(size);
    n_regions++;
  endtask

  // random item: allocations of assorted sizes, frees of held blocks, and
  // some frees of arbitrary offsets that mostly miss
  task automatic random_request();
    int r, k;
    held_t h;
    logic [NEED_W-1:0] sz;
    logic [FIELD_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      k = $urandom_range(0, 99);
      if (k < 30 && freed_sizes.size() > 0) begin
        // ask again for a size that was freed, to hit exact fits
        k  = $urandom_range(0, freed_sizes.size() - 1);
        sz = freed_sizes[k];
        freed_sizes.delete(k);
        v  = (sz >= GRANULE) ? FIELD_W'(sz - $urandom_range(0, GRANULE - 1)) : '0;
      end else if (k < 40) begin
        v = '0;
      end else if (k < 85) begin
        v = FIELD_W'($urandom_range(1, (cur_region >> 5) + 8));
      end else if (k < 95) begin
        v = FIELD_W'($urandom_range(0, cur_region));
      end else begin
        v = rand_field();
      end
      push_request(ACT_ALLOC, v, rand_field());
    end else if (r < 88 && held_q.size() > 0) begin
      k = $urandom_range(0, held_q.size() - 1);
      h = held_q[k];
      held_q.delete(k);
      freed_sizes.push_back(h.size);
      push_request(ACT_FREE, rand_field(), h.addr);
    end else begin
      v = ($urandom_range(0, 3) == 0) ? FIELD_W'($urandom)
                                      : FIELD_W'($urandom_range(0, cur_region) & 16'hFFF8);
      push_request(ACT_FREE, rand_field(), v);
    end
  endtask

  initial begin
    logic [FIELD_W-1:0] region;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, full region after reset
    push_request(ACT_ALLOC, 16'd0, rand_field());     // zero request splits off a zero-length block
    push_request(ACT_ALLOC, 16'd1, rand_field());     // rounds to 8, same offset as the zero block
    push_request(ACT_FREE, rand_field(), 16'd0);      // duplicate offset: newest one goes
    push_request(ACT_FREE, rand_field(), 16'd0);      // then the zero-length one
    push_request(ACT_FREE, rand_field(), 16'd0);      // nothing left at 0
    push_request(ACT_ALLOC, 16'd0, rand_field());     // zero-length free block taken whole
    push_request(ACT_ALLOC, 16'hFFFF, rand_field());  // rounds past any 16-bit region
    push_request(ACT_ALLOC, 16'd8, rand_field());     // exact fit at the free head
    push_request(ACT_ALLOC, 16'd7, rand_field());
    push_request(ACT_FREE, 16'hFFFF, 16'hFFFF);
    push_request(ACT_ALLOC, 16'hFFF8, rand_field());  // just too big for what is left
    push_request(ACT_ALLOC, 16'hFFE8, rand_field());  // large split
    push_request(ACT_FREE, rand_field(), 16'd8);
    push_request(ACT_ALLOC, 16'd8, rand_field());

    // empty region
    write_region(16'd0);
    push_request(ACT_ALLOC, 16'd0, rand_field());
    push_request(ACT_ALLOC, 16'd0, rand_field());     // free list now empty
    push_request(ACT_ALLOC, 16'd1, rand_field());
    push_request(ACT_FREE, rand_field(), 16'd0);
    push_request(ACT_FREE, rand_field(), 16'd0);      // allocated list empty

    // random phases, each on a fresh region; every fourth runs without gaps
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 6)
        0: region = 16'hFFFF;
        1: region = 16'h0000;
        2: region = FIELD_W'($urandom_range(1, 64));
        3: region = FIELD_W'($urandom_range(65, 4096));
        4: region = FIELD_W'($urandom_range(0, 65535));
        default: region = 16'hFFF8;
      endcase
      write_region(region);
      no_idle = (ph % 4 == 3);
      repeat (PHASE_ITEMS) random_request();
    end
    no_idle = 1'b0;

    // drain, then allow a full walk's worth of cycles for anything stray
    s_tvalid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (RECORDS + 8) @(posedge clk);

    $display("run covered %0d requests (%0d allocate, %0d free) over %0d region writes",
             n_alloc + n_free, n_alloc, n_free, n_regions);
    $display("statuses seen: ok %0d, no fit %0d, no spare %0d, not found %0d",
             status_seen[ST_OK], status_seen[ST_NO_FIT], status_seen[ST_NO_SPARE],
             status_seen[ST_NOT_FOUND]);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/ffba_pkg.sv
rtl/core/ffba_rec_mem.sv
rtl/core/ffba_alu.sv
rtl/core/first_fit_block_allocator_core.sv
rtl/core/ffba_checker.sv
verif/ffba_checker.sv
verif/tb_top.sv
